// ----- src/salc_pkg.sv -----
// Package for the set-associative LRU cache tag controller.
// Holds geometry defaults, payload structs and the back-end state enum.
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;
    localparam int SETS_DEF        = 64;
    localparam int WAYS_DEF        = 4;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int ADDR_WIDTH_DEF  = 32;

    localparam int ADDR_W = 32;
    localparam int WAY_W  = 2;
    localparam int SET_W  = 6;
    localparam int ETAG_W = 20;

    typedef enum logic {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [ADDR_W-1:0]   address;
    } t_req;

    typedef struct packed {
        logic                hit;
        logic [WAY_W-1:0]    way;
        logic [SET_W-1:0]    set_number;
        logic                evicted;
        logic [ETAG_W-1:0]   ev_tag;
        logic                ev_dirty;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- src/salc_front.sv -----
// Front end: accepts requests, splits set index and tag, queues them.
// Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module salc_front import salc_pkg::*; #(
    parameter int SETS        = SETS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
    parameter int IB          = 6,
    parameter int TB          = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire t_req          i_req,
    output logic               o_valid,
    input  wire logic          i_take,
    output logic               o_wr,
    output logic [IB-1:0]      o_set,
    output logic [TB-1:0]      o_tag
);
    localparam int OB = $clog2(BLOCK_BYTES + 1) - 1;
    localparam int AB = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
    localparam int EW = 1 + IB + TB;

    logic [1:0][EW-1:0] r_q;
    logic [1:0]         r_cnt;
    logic               r_wp, r_rp;
    logic [63:0]        w_a;
    logic [63:0]        w_sh;
    logic [IB-1:0]      w_set;
    logic [TB-1:0]      w_tag;
    logic               w_push, w_pop;

    always_comb begin
        w_a = 64'(i_req.address) & ((AB >= 64) ? '1 : ((64'd1 << AB) - 64'd1));
        w_sh = w_a >> OB;
        w_set = (SETS > 1) ? IB'(w_sh) : '0;
        if (64'(w_set) >= 64'(SETS)) begin
            w_set = '0;
        end
        w_tag = TB'(w_a >> (OB + ((SETS > 1) ? IB : 0)));
    end

    assign o_full = (r_cnt == 2'd2);
    assign w_push = i_push && !o_full;
    assign w_pop  = i_take && o_valid;
    assign o_valid = (r_cnt != 2'd0);
    assign {o_wr, o_set, o_tag} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= {i_req.action == ACT_WRITE, w_set, w_tag};
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

// ----- src/salc_back.sv -----
// Back end: set memory read, tag compare, victim pick, LRU update, result register.
// Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module salc_back import salc_pkg::*; #(
    parameter int SETS = SETS_DEF,
    parameter int WAYS = WAYS_DEF,
    parameter int IB   = 6,
    parameter int TB   = 20
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_take,
    input  wire logic      i_wr,
    input  wire logic [IB-1:0] i_set,
    input  wire logic [TB-1:0] i_tag,
    output logic           o_empty,
    input  wire logic      i_pop,
    output t_rsp           o_rsp,
    output logic           o_busy
);
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ND = SETS;
    localparam int SA = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LW = 1 + 1 + TB;

    // One row per set: every way's valid, dirty, tag and rank.
    logic [WAYS-1:0][LW-1:0] r_mem  [ND];
    logic [WAYS-1:0][WB-1:0] r_rmem [ND];
    logic [ND-1:0]           r_init;
    logic [SA-1:0]           r_clr;
    logic                    r_clr_on;

    t_state r_st, n_st;
    logic                    r_wr;
    logic [IB-1:0]           r_set;
    logic [TB-1:0]           r_tag;
    logic [WAYS-1:0][LW-1:0] r_row;
    logic [WAYS-1:0][WB-1:0] r_rk;
    logic                    r_inok;
    logic [WAYS-1:0][LW-1:0] n_row;
    logic [WAYS-1:0][WB-1:0] n_rk;
    t_rsp                    r_out, n_out;
    logic                    r_has;

    logic [SA-1:0] w_sa;
    assign w_sa = SA'(i_set);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_valid && !r_clr_on) n_st = ST_READ;
            ST_READ: n_st = ST_CMP;
            ST_CMP:  n_st = ST_OUT;
            ST_OUT:  if (!r_has || i_pop) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_take = (r_st == ST_IDLE) && i_valid && !r_clr_on;
    assign o_busy = r_clr_on;

    always_comb begin
        logic            hit, fnd;
        logic [WB-1:0]   hw, vw;
        logic [WB-1:0]   old;
        logic [WAYS-1:0][LW-1:0] row;
        logic [WAYS-1:0][WB-1:0] rk;
        row = r_row;
        rk = r_rk;
        if (!r_inok) begin
            row = '0;
            for (int w = 0; w < WAYS; w++) rk[w] = WB'(w);
        end
        hit = 1'b0; hw = '0; fnd = 1'b0; vw = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row[w][LW-1] && row[w][TB-1:0] == r_tag) begin
                hit = 1'b1; hw = WB'(w);
            end
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!row[w][LW-1]) begin
                fnd = 1'b1; vw = WB'(w);
            end
        end
        if (!fnd) begin
            for (int w = WAYS - 1; w >= 0; w--) begin
                if (rk[w] == '0) vw = WB'(w);
            end
        end
        if (hit) vw = hw;
        n_out = '0;
        n_out.hit = hit;
        n_out.way = WAY_W'(vw);
        n_out.set_number = SET_W'(r_set);
        if (!hit && row[vw][LW-1]) begin
            n_out.evicted = 1'b1;
            n_out.ev_tag = ETAG_W'(row[vw][TB-1:0]);
            n_out.ev_dirty = row[vw][LW-2];
        end
        n_row = row;
        if (hit) begin
            if (r_wr) n_row[vw][LW-2] = 1'b1;
        end else begin
            n_row[vw] = {1'b1, r_wr, r_tag};
        end
        old = rk[vw];
        n_rk = rk;
        for (int w = 0; w < WAYS; w++) begin
            if (rk[w] > old) n_rk[w] = rk[w] - WB'(1);
        end
        n_rk[vw] = WB'(WAYS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_wr <= i_wr; r_set <= i_set; r_tag <= i_tag;
        end
        if (r_st == ST_READ) begin
            r_row <= r_mem[SA'(r_set)];
            r_rk  <= r_rmem[SA'(r_set)];
            r_inok <= r_init[SA'(r_set)];
        end
        if (r_st == ST_CMP) begin
            r_mem[SA'(r_set)]  <= n_row;
            r_rmem[SA'(r_set)] <= n_rk;
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_has <= 1'b0;
            r_init <= '0;
            r_clr <= '0;
            r_clr_on <= 1'b0;
        end else begin
            r_st <= n_st;
            r_clr_on <= 1'b0;
            if (r_st == ST_CMP) begin
                r_has <= 1'b1;
                r_init[SA'(r_set)] <= 1'b1;
            end else if (r_has && i_pop) begin
                r_has <= 1'b0;
            end
        end
    end

    assign o_empty = !(r_has && r_st == ST_OUT);
    assign o_rsp = r_out;
    logic unused;
    assign unused = ^{r_clr, w_sa};
endmodule
`default_nettype wire

// ----- src/set_assoc_lru_cache_tags_top.sv -----
// Top level of the set-associative LRU cache tag controller.
// Depends on salc_pkg, salc_front and salc_back.
// The back end handles one access at a time: row read, compare and
// update, result hand-off, and it takes no new access until the result
// is popped. The front queue holds two accesses so push runs ahead of the
// back end. Valid, dirty and LRU state read as reset by per-set valid bits.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_tags_top import salc_pkg::*; #(
    parameter int SETS        = SETS_DEF,
    parameter int WAYS        = WAYS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_req i_req,
    output logic      empty,
    input  wire logic pop,
    output t_rsp      o_rsp
);
    localparam int IB = (SETS > 1) ? $clog2(SETS + 1) - 1 : 1;
    localparam int OB = $clog2(BLOCK_BYTES + 1) - 1;
    localparam int TBR = ADDR_W - OB - ((SETS > 1) ? IB : 0);
    localparam int TB = (TBR > 0) ? TBR : 1;

    logic          w_valid, w_take, w_wr, w_busy;
    logic [IB-1:0] w_set;
    logic [TB-1:0] w_tag;

    salc_front #(.SETS(SETS), .BLOCK_BYTES(BLOCK_BYTES), .ADDR_WIDTH(ADDR_WIDTH),
                 .IB(IB), .TB(TB)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_req,
        .o_valid(w_valid), .i_take(w_take), .o_wr(w_wr), .o_set(w_set), .o_tag(w_tag)
    );

    salc_back #(.SETS(SETS), .WAYS(WAYS), .IB(IB), .TB(TB)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .o_take(w_take), .i_wr(w_wr),
        .i_set(w_set), .i_tag(w_tag), .o_empty(empty), .i_pop(pop), .o_rsp,
        .o_busy(w_busy)
    );
    logic unused;
    assign unused = w_busy;
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for set_assoc_lru_cache_tags_top: tag lookup, LRU victim choice and eviction.
// Depends on salc_pkg and the top level; predicts every result and checks it in order.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import salc_pkg::*;

    localparam int NSETS     = 64;
    localparam int NWAYS     = 4;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1700;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_req i_req = '0;
    logic full;
    logic empty;
    t_rsp o_rsp;

    set_assoc_lru_cache_tags_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_req(i_req),
        .empty(empty), .pop(pop), .o_rsp(o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the tag array.
    logic               tag_valid [NSETS][NWAYS];
    logic               tag_dirty [NSETS][NWAYS];
    logic [ETAG_W-1:0]  tag_value [NSETS][NWAYS];
    int unsigned        recency   [NSETS][NWAYS];

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   n_hits = 0;
    int   n_evicts = 0;
    int   n_dirty_evicts = 0;
    bit   send_hold = 1'b0;   // sender pause until drained
    bit   recv_hold = 1'b0;   // receiver long hold-off
    bit   calm = 1'b0;        // no random idling
    int   wdog = 0;

    function automatic void make_recent(input int s, input int w);
        int old_rank;
        old_rank = recency[s][w];
        for (int i = 0; i < NWAYS; i++)
            if (recency[s][i] > old_rank) recency[s][i]--;
        recency[s][w] = NWAYS - 1;
    endfunction

    function automatic t_rsp lookup_access(input t_req r);
        t_rsp p;
        int s;
        int w;
        bit found;
        logic [ETAG_W-1:0] tg;
        p = '0;
        s = r.address[11:6];
        tg = r.address[31:12];
        p.set_number = s[5:0];
        found = 1'b0;
        for (int i = 0; i < NWAYS; i++) begin
            if (!found && tag_valid[s][i] && tag_value[s][i] == tg) begin
                found = 1'b1;
                w = i;
            end
        end
        if (found) begin
            p.hit = 1'b1;
            if (r.action == ACT_WRITE) tag_dirty[s][w] = 1'b1;
        end else begin
            w = -1;
            for (int i = 0; i < NWAYS; i++)
                if (w < 0 && !tag_valid[s][i]) w = i;
            if (w < 0)
                for (int i = 0; i < NWAYS; i++)
                    if (w < 0 && recency[s][i] == 0) w = i;
            if (tag_valid[s][w]) begin
                p.evicted = 1'b1;
                p.ev_tag = tag_value[s][w];
                p.ev_dirty = tag_dirty[s][w];
            end
            tag_valid[s][w] = 1'b1;
            tag_value[s][w] = tg;
            tag_dirty[s][w] = (r.action == ACT_WRITE);
        end
        make_recent(s, w);
        p.way = w[1:0];
        return p;
    endfunction

    // Driver: offer the head of the pending queue.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                expected_rsps.push_back(lookup_access(i_req));
                void'(pending_reqs.pop_front());
            end
            if (pending_reqs.size() > 0 && !send_hold &&
                (calm || $urandom_range(99) >= 32)) begin
                push <= 1'b1;
                i_req <= pending_reqs[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: accept and check results.
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_rsps.size() == 0) begin
                    $error("result with nothing expected: %p", o_rsp);
                    errors++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (o_rsp.hit !== e.hit) begin
                        $error("hit: expected %0d, got %0d", e.hit, o_rsp.hit); errors++;
                    end
                    if (o_rsp.way !== e.way) begin
                        $error("way: expected %0d, got %0d", e.way, o_rsp.way); errors++;
                    end
                    if (o_rsp.set_number !== e.set_number) begin
                        $error("set_number: expected %0d, got %0d",
                               e.set_number, o_rsp.set_number); errors++;
                    end
                    if (o_rsp.evicted !== e.evicted) begin
                        $error("evicted: expected %0d, got %0d", e.evicted, o_rsp.evicted);
                        errors++;
                    end
                    if (o_rsp.ev_tag !== e.ev_tag) begin
                        $error("ev_tag: expected %h, got %h",
                               e.ev_tag, o_rsp.ev_tag); errors++;
                    end
                    if (o_rsp.ev_dirty !== e.ev_dirty) begin
                        $error("ev_dirty: expected %0d, got %0d",
                               e.ev_dirty, o_rsp.ev_dirty); errors++;
                    end
                    if (e.hit) n_hits++;
                    if (e.evicted) n_evicts++;
                    if (e.ev_dirty) n_dirty_evicts++;
                end
            end
            pop <= !recv_hold && (calm || $urandom_range(99) >= 32);
        end
    end

    // Watchdog: count cycles with no accepted item on either side, outside receiver hold-off.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || recv_hold || !i_rst_n) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("timeout: %0d pending, %0d expected",
                     pending_reqs.size(), expected_rsps.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_req mk(input t_action a, input logic [19:0] tg,
                                input logic [5:0] s, input logic [5:0] off);
        t_req r;
        r.action = a;
        r.address = {tg, s, off};
        return r;
    endfunction

    // Long receiver hold-off while the sender keeps offering items.
    task automatic hold_receiver(input int cycles);
        recv_hold = 1'b1;
        repeat (cycles) @(posedge i_clk);
        recv_hold = 1'b0;
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0);
        wait (expected_rsps.size() == 0);
    endtask

    initial begin
        t_req r;
        int s;
        logic [19:0] pool [8];
        for (int i = 0; i < NSETS; i++)
            for (int j = 0; j < NWAYS; j++) begin
                tag_valid[i][j] = 1'b0;
                tag_dirty[i][j] = 1'b0;
                tag_value[i][j] = '0;
                recency[i][j] = j;
            end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill a set, hit, dirty-hit, evict clean and dirty, extremes.
        pending_reqs.push_back(mk(ACT_READ, 20'h00000, 6'd0, 6'd0));
        pending_reqs.push_back(mk(ACT_WRITE, 20'hFFFFF, 6'd63, 6'd63));
        pending_reqs.push_back(mk(ACT_WRITE, 20'h00001, 6'd0, 6'd5));
        pending_reqs.push_back(mk(ACT_READ, 20'h00002, 6'd0, 6'd9));
        pending_reqs.push_back(mk(ACT_READ, 20'h00003, 6'd0, 6'd1));
        pending_reqs.push_back(mk(ACT_READ, 20'h00000, 6'd0, 6'd2));   // hit way 0
        pending_reqs.push_back(mk(ACT_WRITE, 20'h00002, 6'd0, 6'd3));  // dirty a hit
        pending_reqs.push_back(mk(ACT_READ, 20'h00004, 6'd0, 6'd0));   // evict dirty tag 1
        pending_reqs.push_back(mk(ACT_READ, 20'h00005, 6'd0, 6'd0));   // evict clean tag 3
        pending_reqs.push_back(mk(ACT_READ, 20'hFFFFF, 6'd63, 6'd0));  // hit top corner
        pending_reqs.push_back(mk(ACT_WRITE, 20'hAAAAA, 6'd42, 6'd42));
        pending_reqs.push_back(mk(ACT_WRITE, 20'h55555, 6'd21, 6'd21));
        pending_reqs.push_back(mk(ACT_READ, 20'h00000, 6'd0, 6'd0));
        drain();

        // Fill the block while the receiver holds off.
        for (int i = 0; i < 40; i++)
            pending_reqs.push_back(mk(t_action'($urandom_range(1)), 20'($urandom_range(3)),
                                      6'($urandom_range(3)), 6'($urandom)));
        calm = 1'b1;
        hold_receiver(300);
        drain();
        calm = 1'b0;

        // Random: small tag pool per phase so hits and evictions both occur.
        for (int ph = 0; ph < 17; ph++) begin
            for (int k = 0; k < 8; k++) pool[k] = 20'($urandom);
            for (int i = 0; i < N_RANDOM / 17; i++) begin
                if ($urandom_range(9) == 0) begin
                    r.action = t_action'($urandom_range(1));
                    r.address = $urandom;
                end else begin
                    s = (ph % 3 == 0) ? $urandom_range(63) : $urandom_range(3);
                    r = mk(t_action'($urandom_range(1)), pool[$urandom_range(7)],
                           6'(s), 6'($urandom));
                end
                pending_reqs.push_back(r);
            end
            calm = (ph == 8);
            if (ph == 5) begin
                // Sender pauses midway until every result is back.
                wait (pending_reqs.size() <= N_RANDOM / 34);
                send_hold = 1'b1;
                @(posedge i_clk);
                wait (expected_rsps.size() == 0);
                send_hold = 1'b0;
            end
            drain();
        end
        calm = 1'b0;
        repeat (20) @(posedge i_clk);

        $display("covered %0d hits, %0d evictions (%0d dirty)",
                 n_hits, n_evicts, n_dirty_evicts);
        $display("over directed, back-pressure and random accesses");
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
src/salc_pkg.sv
src/salc_front.sv
src/salc_back.sv
src/set_assoc_lru_cache_tags_top.sv
test/tb.sv
